[rtl/rhc_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every module in rtl/.
package rhc_pkg;

  localparam int CHAN_W  = 8;   // one colour channel
  localparam int HUE_W   = 9;   // whole degrees
  localparam int PCT_W   = 15;  // percent, 8 fraction bits
  localparam int NUM_W   = 23;  // dividend of both divisions
  localparam int QUO_W   = 16;  // quotient bits produced by the divider
  localparam int DEN_W   = 8;   // divisor width

  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;

  // Everything the front end hands to the dividers and the output stage.
  typedef struct packed {
    logic [NUM_W-1:0]  hue_num;
    logic [NUM_W-1:0]  sat_num;
    logic [DEN_W-1:0]  diff;
    logic [DEN_W-1:0]  max;
    logic [PCT_W-1:0]  val;
    logic              gray;
    logic              black;
  } front_t;

  // Sideband that bypasses the dividers.
  typedef struct packed {
    logic [PCT_W-1:0] val;
    logic             gray;
    logic             black;
  } side_t;

endpackage

[rtl/rhc_front.sv]
// Front end: channel max/min, hue and saturation dividends, brightness.
// Two register stages; depends on rhc_pkg.
module rhc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [rhc_pkg::CHAN_W-1:0]   in_red,
  input  logic [rhc_pkg::CHAN_W-1:0]   in_green,
  input  logic [rhc_pkg::CHAN_W-1:0]   in_blue,
  output logic                         out_vld,
  output rhc_pkg::front_t              out_data
);
  import rhc_pkg::*;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // stage 1
  logic              vld1_r;
  logic [CHAN_W-1:0] max_r, max_nxt;
  logic [CHAN_W-1:0] diff_r, diff_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic signed [CHAN_W:0] dxy_r, dxy_nxt;
  logic [CHAN_W-1:0] min_c;

  // stage 2
  logic   vld2_r;
  front_t data_r, data_nxt;

  logic signed [19:0] num_c;
  logic signed [19:0] off_c;
  logic [14:0]        t_c;
  logic [14:0]        q_c;

  // Ties go red first, then green.
  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      sel_nxt = SEL_RED;
      max_nxt = in_red;
      dxy_nxt = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green >= in_blue) begin
      sel_nxt = SEL_GREEN;
      max_nxt = in_green;
      dxy_nxt = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      sel_nxt = SEL_BLUE;
      max_nxt = in_blue;
      dxy_nxt = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
    min_c = in_red;
    if (in_green < min_c) min_c = in_green;
    if (in_blue < min_c)  min_c = in_blue;
    diff_nxt = max_nxt - min_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    max_r  <= max_nxt;
    diff_r <= diff_nxt;
    sel_r  <= sel_nxt;
    dxy_r  <= dxy_nxt;
  end

  always_comb begin
    case (sel_r)
      SEL_RED:   off_c = 20'sd360;
      SEL_GREEN: off_c = 20'sd120;
      SEL_BLUE:  off_c = 20'sd240;
      default:   off_c = 20'sd0;
    endcase
    // Always positive for a non-gray pixel, zero for a gray one.
    num_c = 20'(dxy_r) * 20'sd60 + off_c * $signed({12'd0, diff_r});

    // max*25600/255 = t + floor(t/255) with t = max*100
    t_c = 15'(max_r) * 15'd100;
    q_c = (t_c + (t_c >> 8) + 15'd1) >> 8;

    data_nxt.hue_num = {3'd0, num_c};
    data_nxt.sat_num = {15'(diff_r) * 15'd100, 8'd0};
    data_nxt.diff    = diff_r;
    data_nxt.max     = max_r;
    data_nxt.val     = t_c + q_c;
    data_nxt.gray    = (diff_r == '0);
    data_nxt.black   = (max_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    data_r <= data_nxt;
  end

  assign out_vld  = vld2_r;
  assign out_data = data_r;

endmodule

[rtl/rhc_div.sv]
// Pipelined restoring divider, a few quotient bits per register stage.
// Quotient must fit QUO_W bits; depends on rhc_pkg.
module rhc_div (
  input  logic                        clk,
  input  logic [rhc_pkg::NUM_W-1:0]   num,
  input  logic [rhc_pkg::DEN_W-1:0]   den,
  output logic [rhc_pkg::QUO_W-1:0]   quo
);
  import rhc_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] work;  // dividend bits still to shift in, quotient bits shift in below
    logic [DEN_W-1:0] den;
  } div_st_t;

  div_st_t init_c;
  div_st_t stage_r   [DIV_STAGES];
  div_st_t stage_nxt [DIV_STAGES];

  function automatic div_st_t run_steps(input div_st_t s);
    div_st_t      o;
    logic [DEN_W:0] t;
    o = s;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      t = {o.rem, o.work[QUO_W-1]};
      if (t >= {1'b0, o.den}) begin
        t      = t - {1'b0, o.den};
        o.work = {o.work[QUO_W-2:0], 1'b1};
      end else begin
        o.work = {o.work[QUO_W-2:0], 1'b0};
      end
      o.rem = t[DEN_W-1:0];
    end
    return o;
  endfunction

  always_comb begin
    init_c.rem  = DEN_W'(num[NUM_W-1:QUO_W]);
    init_c.work = num[QUO_W-1:0];
    init_c.den  = den;
    stage_nxt[0] = run_steps(init_c);
    for (int s = 1; s < DIV_STAGES; s++) begin
      stage_nxt[s] = run_steps(stage_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      stage_r[s] <= stage_nxt[s];
    end
  end

  assign quo = stage_r[DIV_STAGES-1].work;

endmodule

[rtl/rgb_to_hsv_converter_core.sv]
// RGB to HSV converter, top level: one pixel per clock in, one result beat out.
// Uses rhc_front, rhc_div and rhc_pkg.
//
// A pixel is taken on every clock edge with start high; busy is always low, so
// a new pixel may follow in every cycle. Its result appears for one cycle with
// out_valid high after two front-end stages (max/min, then the
// dividends and brightness), four stages of the pipelined dividers at four
// quotient bits each, and the output register. The receiver must take every
// beat; there is no way to hold results off.
module rgb_to_hsv_converter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rhc_pkg::CHAN_W-1:0]   in_red,
  input  logic [rhc_pkg::CHAN_W-1:0]   in_green,
  input  logic [rhc_pkg::CHAN_W-1:0]   in_blue,
  output logic                         out_valid,
  output logic [rhc_pkg::HUE_W-1:0]    out_hue,
  output logic [rhc_pkg::PCT_W-1:0]    out_saturation,
  output logic [rhc_pkg::PCT_W-1:0]    out_brightness
);
  import rhc_pkg::*;

  logic             front_vld;
  front_t           front_data;
  logic [QUO_W-1:0] hue_quo;
  logic [QUO_W-1:0] sat_quo;

  logic [DIV_STAGES-1:0] vld_r, vld_nxt;
  side_t                 side_r [DIV_STAGES];

  logic             out_vld_r;
  logic [HUE_W-1:0] hue_r, hue_nxt;
  logic [PCT_W-1:0] sat_r, sat_nxt;
  logic [PCT_W-1:0] val_r;
  logic [HUE_W-1:0] hue_q;
  side_t            side_in;

  assign busy = 1'b0;

  rhc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  rhc_div u_hue_div (
    .clk (clk),
    .num (front_data.hue_num),
    .den (front_data.diff),
    .quo (hue_quo)
  );

  rhc_div u_sat_div (
    .clk (clk),
    .num (front_data.sat_num),
    .den (front_data.max),
    .quo (sat_quo)
  );

  // Carry brightness and the special-case flags alongside the dividers.
  always_comb begin
    side_in.val   = front_data.val;
    side_in.gray  = front_data.gray;
    side_in.black = front_data.black;
    vld_nxt = {vld_r[DIV_STAGES-2:0], front_vld};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    side_r[0] <= side_in;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  // Quotient lies in 60..420: one subtract wraps it.
  always_comb begin
    hue_q = hue_quo[HUE_W-1:0];
    if (side_r[DIV_STAGES-1].gray) begin
      hue_nxt = '0;
    end else if (hue_q >= HUE_WRAP) begin
      hue_nxt = hue_q - HUE_WRAP;
    end else begin
      hue_nxt = hue_q;
    end
    if (side_r[DIV_STAGES-1].black) begin
      sat_nxt = '0;
    end else begin
      sat_nxt = sat_quo[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[DIV_STAGES-1];
    end
    hue_r <= hue_nxt;
    sat_r <= sat_nxt;
    val_r <= side_r[DIV_STAGES-1].val;
  end

  assign out_valid      = out_vld_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;

endmodule
